// ----- rtl/core/plpc_pkg.sv -----
// Shared constants, codes and controller/datapath link types for the line pointer checker.
package plpc_pkg;

	localparam int MAX_SPANS = 512;
	localparam int IDX_W     = $clog2(MAX_SPANS);
	localparam int SCNT_W    = $clog2(MAX_SPANS + 1);

	localparam int POS_W   = 15;
	localparam int END_W   = 16;
	localparam int CNT_W   = 10;
	localparam int TOTAL_W = 16;
	localparam int SPAN_W  = POS_W + END_W;

	localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	localparam logic [1:0] FLAG_UNUSED   = 2'd0;
	localparam logic [1:0] FLAG_NORMAL   = 2'd1;
	localparam logic [1:0] FLAG_REDIRECT = 2'd2;
	localparam logic [1:0] FLAG_DEAD     = 2'd3;

	localparam logic [1:0] REG_UPPER   = 2'd0;
	localparam logic [1:0] REG_SPECIAL = 2'd1;

	localparam logic [POS_W-1:0] UPPER_RST   = 15'd0;
	localparam logic [POS_W-1:0] SPECIAL_RST = 15'd32767;

	typedef struct packed {
		logic load;
		logic rd;
		logic fin;
	} plpc_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic out_free;
	} plpc_sts_t;

endpackage

// ----- rtl/core/plpc_if.sv -----
// Request and result channel interfaces of the line pointer checker.
interface plpc_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  item_flag;
	logic [14:0] item_offset;
	logic [14:0] item_length;
	logic        last_item;

	modport source (output valid, item_flag, item_offset, item_length, last_item,
		input ready);
	modport sink (input valid, item_flag, item_offset, item_length, last_item,
		output ready);
endinterface

interface plpc_result_if;
	logic        valid;
	logic        ready;
	logic        flag_length_error;
	logic        zero_length_error;
	logic        zero_offset_error;
	logic        below_upper_error;
	logic        beyond_special_error;
	logic [9:0]  overlap_count;
	logic [9:0]  item_errors;
	logic [15:0] page_errors;
	logic        table_full;
	logic        page_done;

	modport source (output valid, flag_length_error, zero_length_error,
		zero_offset_error, below_upper_error, beyond_special_error, overlap_count,
		item_errors, page_errors, table_full, page_done, input ready);
	modport sink (input valid, flag_length_error, zero_length_error,
		zero_offset_error, below_upper_error, beyond_special_error, overlap_count,
		item_errors, page_errors, table_full, page_done, output ready);
endinterface

// ----- rtl/core/plpc_ctrl.sv -----
// Controller state machine: accept, scan the span table, finish the request.
module plpc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  plpc_pkg::plpc_sts_t sts,
	output plpc_pkg::plpc_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.scan_done) begin
					state_nxt = ST_FIN;
				end else begin
					cmd.rd = 1'b1;
				end
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.fin   = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ----- rtl/core/plpc_dp.sv -----
// Datapath: configuration registers, span table memory, overlap scan and result register.
module plpc_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_idx,
	input  logic [14:0]         cfg_data,
	input  plpc_pkg::plpc_cmd_t cmd,
	output plpc_pkg::plpc_sts_t sts,
	plpc_item_if.sink           items,
	plpc_result_if.source       results
);

	logic [plpc_pkg::POS_W-1:0]   upper_q;
	logic [plpc_pkg::POS_W-1:0]   special_q;

	logic [1:0]                   flag_q;
	logic [plpc_pkg::POS_W-1:0]   off_q;
	logic [plpc_pkg::POS_W-1:0]   len_q;
	logic                         last_q;
	logic                         stor_q;

	logic [plpc_pkg::SCNT_W-1:0]  rd_idx_q;
	logic [plpc_pkg::SCNT_W-1:0]  count_q;
	logic [plpc_pkg::CNT_W-1:0]   ovl_q;
	logic [plpc_pkg::TOTAL_W-1:0] total_q;
	logic                         rd_vld_s1;
	logic [plpc_pkg::SPAN_W-1:0]  rdata_s1;

	logic [plpc_pkg::SPAN_W-1:0]  span_mem [plpc_pkg::MAX_SPANS];

	logic                         in_stor;
	logic [plpc_pkg::END_W-1:0]   a_v;
	logic [plpc_pkg::END_W-1:0]   b_v;
	logic [plpc_pkg::END_W-1:0]   c_v;
	logic [plpc_pkg::END_W-1:0]   d_v;
	logic                         hit;
	logic                         room;
	logic                         e_flag;
	logic                         e_zlen;
	logic                         e_zoff;
	logic                         e_below;
	logic                         e_beyond;
	logic [plpc_pkg::CNT_W:0]     item_sum;
	logic [plpc_pkg::CNT_W-1:0]   item_sat;
	logic [plpc_pkg::TOTAL_W:0]   total_sum;
	logic [plpc_pkg::TOTAL_W-1:0] total_sat;

	logic                         out_valid_q;
	logic                         o_flag_q;
	logic                         o_zlen_q;
	logic                         o_zoff_q;
	logic                         o_below_q;
	logic                         o_beyond_q;
	logic [plpc_pkg::CNT_W-1:0]   o_ovl_q;
	logic [plpc_pkg::CNT_W-1:0]   o_item_q;
	logic [plpc_pkg::TOTAL_W-1:0] o_total_q;
	logic                         o_full_q;
	logic                         o_done_q;

	assign in_stor = (items.item_flag == plpc_pkg::FLAG_NORMAL) ||
		((items.item_flag == plpc_pkg::FLAG_DEAD) && (items.item_length != '0));

	// Span of the held item and the span last read from the table.
	assign a_v = {1'b0, off_q};
	assign b_v = {1'b0, off_q} + {1'b0, len_q};
	assign c_v = {1'b0, rdata_s1[plpc_pkg::SPAN_W-1 -: plpc_pkg::POS_W]};
	assign d_v = rdata_s1[plpc_pkg::END_W-1:0];

	assign hit = ((a_v < c_v) && (c_v < b_v)) || ((a_v < d_v) && (d_v < b_v)) ||
		((c_v < a_v) && (a_v < d_v)) || ((c_v < b_v) && (b_v < d_v));

	assign room = count_q < plpc_pkg::SCNT_W'(plpc_pkg::MAX_SPANS);

	assign e_flag   = !stor_q && ((flag_q == plpc_pkg::FLAG_UNUSED) ||
		(flag_q == plpc_pkg::FLAG_REDIRECT)) && (len_q != '0);
	assign e_zlen   = stor_q && (len_q == '0);
	assign e_zoff   = stor_q && (off_q == '0);
	assign e_below  = stor_q && (off_q < upper_q);
	assign e_beyond = stor_q && (b_v > {1'b0, special_q});

	always_comb begin
		item_sum = {1'b0, ovl_q} + (plpc_pkg::CNT_W + 1)'(e_flag) +
			(plpc_pkg::CNT_W + 1)'(e_zlen) + (plpc_pkg::CNT_W + 1)'(e_zoff) +
			(plpc_pkg::CNT_W + 1)'(e_below) + (plpc_pkg::CNT_W + 1)'(e_beyond);
		item_sat = item_sum[plpc_pkg::CNT_W] ? plpc_pkg::CNT_MAX :
			item_sum[plpc_pkg::CNT_W-1:0];
		total_sum = {1'b0, total_q} + (plpc_pkg::TOTAL_W + 1)'(item_sat);
		total_sat = total_sum[plpc_pkg::TOTAL_W] ? plpc_pkg::TOTAL_MAX :
			total_sum[plpc_pkg::TOTAL_W-1:0];
	end

	assign sts.scan_done = !stor_q || (rd_idx_q == count_q);
	assign sts.out_free  = !out_valid_q || results.ready;

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rdata_s1 <= span_mem[rd_idx_q[plpc_pkg::IDX_W-1:0]];
		end
		if (cmd.fin && stor_q && room) begin
			span_mem[count_q[plpc_pkg::IDX_W-1:0]] <= {off_q, b_v};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			flag_q <= items.item_flag;
			off_q  <= items.item_offset;
			len_q  <= items.item_length;
			last_q <= items.last_item;
			stor_q <= in_stor;
		end
		if (cmd.fin) begin
			o_flag_q   <= e_flag;
			o_zlen_q   <= e_zlen;
			o_zoff_q   <= e_zoff;
			o_below_q  <= e_below;
			o_beyond_q <= e_beyond;
			o_ovl_q    <= ovl_q;
			o_item_q   <= item_sat;
			o_total_q  <= total_sat;
			o_full_q   <= stor_q && !room;
			o_done_q   <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q     <= plpc_pkg::UPPER_RST;
			special_q   <= plpc_pkg::SPECIAL_RST;
			rd_idx_q    <= '0;
			rd_vld_s1   <= 1'b0;
			ovl_q       <= '0;
			count_q     <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					plpc_pkg::REG_UPPER:   upper_q   <= cfg_data;
					plpc_pkg::REG_SPECIAL: special_q <= cfg_data;
					default: ;
				endcase
			end
			rd_vld_s1 <= cmd.rd;
			if (cmd.load) begin
				rd_idx_q <= '0;
				ovl_q    <= '0;
			end else begin
				if (cmd.rd) begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
				if (rd_vld_s1 && hit && (ovl_q != plpc_pkg::CNT_MAX)) begin
					ovl_q <= ovl_q + 1'b1;
				end
			end
			if (cmd.fin) begin
				if (last_q) begin
					count_q <= '0;
					total_q <= '0;
				end else begin
					total_q <= total_sat;
					if (stor_q && room) begin
						count_q <= count_q + 1'b1;
					end
				end
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign results.valid                = out_valid_q;
	assign results.flag_length_error    = o_flag_q;
	assign results.zero_length_error    = o_zlen_q;
	assign results.zero_offset_error    = o_zoff_q;
	assign results.below_upper_error    = o_below_q;
	assign results.beyond_special_error = o_beyond_q;
	assign results.overlap_count        = o_ovl_q;
	assign results.item_errors          = o_item_q;
	assign results.page_errors          = o_total_q;
	assign results.table_full           = o_full_q;
	assign results.page_done            = o_done_q;

endmodule

// ----- rtl/core/page_line_pointer_checker_core.sv -----
// Top level of the line pointer checker: controller, datapath and checks.
//
//   channel   dir  handshake              payload
//   items     in   items.valid/ready      item_flag, item_offset, item_length, last_item
//   results   out  results.valid/ready    error bits, counts, page_errors, page_done
//   cfg       in   cfg_we                 cfg_idx, cfg_data (page_upper, page_special)
//
// A request with storage is checked against the N spans stored so far on the page
// (at most 512); the span table is read one entry per cycle through its single read port.
// A request without storage skips the scan.
// arst_n clears the span count, page total, registers and control; the table needs no clear.
// A result waits in the output register; a new request is taken while it waits, and only
// the finishing step stalls until the output register is free.
module page_line_pointer_checker_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_idx,
	input  logic [14:0]   cfg_data,
	plpc_item_if.sink     items,
	plpc_result_if.source results
);

	plpc_pkg::plpc_cmd_t cmd;
	plpc_pkg::plpc_sts_t sts;

	plpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (items.valid),
		.in_ready (items.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	plpc_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.sts      (sts),
		.items    (items),
		.results  (results)
	);

	// Once a request is taken, no other is taken until it has finished.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(items.valid && items.ready) |=> !items.ready)
		else $error("request accepted while another was in progress");

	a_fin_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> sts.out_free)
		else $error("result finished into an occupied output register");

	a_no_read_past_end: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> !sts.scan_done)
		else $error("span table read past the stored spans");

	a_fin_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> results.valid)
		else $error("finished request did not produce a result");

endmodule

// ----- test/page_line_pointer_checker_core_tb.sv -----
// Self-checking line pointer checker testbench: directed, random, full table, receiver hold-off.
module page_line_pointer_checker_core_tb;

	// Indexes past the two registers are decoded as no-ops by the block.
	localparam logic [1:0] REG_SPARE_A = 2'd2;
	localparam logic [1:0] REG_SPARE_B = 2'd3;

	typedef struct packed {
		bit [1:0]  flag;
		bit [14:0] offset;
		bit [14:0] length;
		bit        last;
	} line_ptr_t;

	typedef struct packed {
		bit                         flag_len;
		bit                         zero_len;
		bit                         zero_off;
		bit                         below;
		bit                         beyond;
		bit [plpc_pkg::CNT_W-1:0]   overlaps;
		bit [plpc_pkg::CNT_W-1:0]   item_errs;
		bit [plpc_pkg::TOTAL_W-1:0] page_total;
		bit                         full;
		bit                         done;
	} verdict_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_idx;
	logic [14:0] cfg_data;

	plpc_item_if   items_if();
	plpc_result_if results_if();

	page_line_pointer_checker_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.items(items_if),
		.results(results_if)
	);

	always #4 clk = ~clk;

	// Shadow copy of the page state and the two bound registers.
	bit [plpc_pkg::POS_W-1:0] upper_reg = plpc_pkg::UPPER_RST;
	bit [plpc_pkg::POS_W-1:0] special_reg = plpc_pkg::SPECIAL_RST;
	bit [plpc_pkg::POS_W-1:0] span_lo [plpc_pkg::MAX_SPANS];
	bit [plpc_pkg::END_W-1:0] span_hi [plpc_pkg::MAX_SPANS];
	int                       stored_spans = 0;
	int                       page_sum = 0;

	verdict_t expected_verdicts[$];
	verdict_t got_v;
	verdict_t want_v;
	int       mismatches = 0;
	int       send_idle_pct;
	int       recv_idle_pct;
	int       hold_left = 0;

	function automatic bit strictly_between(int lo, int x, int hi);
		return lo < x && x < hi;
	endfunction

	function automatic verdict_t score_line_pointer(line_ptr_t lp);
		verdict_t v;
		bit       has_storage;
		int       a, b, c, d, hits, sum;
		v = '0;
		hits = 0;
		has_storage = (lp.flag == plpc_pkg::FLAG_NORMAL) ||
			(lp.flag == plpc_pkg::FLAG_DEAD && lp.length != 0);
		a = int'(lp.offset);
		b = a + int'(lp.length);
		if (lp.flag == plpc_pkg::FLAG_UNUSED || lp.flag == plpc_pkg::FLAG_REDIRECT) begin
			v.flag_len = lp.length != 0;
		end else if (has_storage) begin
			v.zero_len = lp.length == 0;
			v.zero_off = lp.offset == 0;
			v.below = lp.offset < upper_reg;
			v.beyond = b > int'(special_reg);
			for (int k = 0; k < stored_spans; k++) begin
				c = int'(span_lo[k]);
				d = int'(span_hi[k]);
				// Shared endpoints and identical spans do not count as overlaps.
				if (strictly_between(a, c, b) || strictly_between(a, d, b) ||
						strictly_between(c, a, d) || strictly_between(c, b, d)) begin
					if (hits < int'(plpc_pkg::CNT_MAX))
						hits++;
				end
			end
			if (stored_spans < plpc_pkg::MAX_SPANS) begin
				span_lo[stored_spans] = lp.offset;
				span_hi[stored_spans] = plpc_pkg::END_W'(b);
				stored_spans++;
			end else begin
				v.full = 1'b1;
			end
		end
		sum = int'(v.flag_len) + int'(v.zero_len) + int'(v.zero_off) + int'(v.below) +
			int'(v.beyond) + hits;
		if (sum > int'(plpc_pkg::CNT_MAX))
			sum = int'(plpc_pkg::CNT_MAX);
		page_sum += sum;
		if (page_sum > int'(plpc_pkg::TOTAL_MAX))
			page_sum = int'(plpc_pkg::TOTAL_MAX);
		v.overlaps = plpc_pkg::CNT_W'(hits);
		v.item_errs = plpc_pkg::CNT_W'(sum);
		v.page_total = plpc_pkg::TOTAL_W'(page_sum);
		v.done = lp.last;
		if (lp.last) begin
			stored_spans = 0;
			page_sum = 0;
		end
		return v;
	endfunction

	function automatic line_ptr_t make_lp(bit [1:0] flag, int off, int len, bit last);
		line_ptr_t lp;
		lp.flag = flag;
		lp.offset = 15'(off);
		lp.length = 15'(len);
		lp.last = last;
		return lp;
	endfunction

	task automatic report_mismatch(string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic compare_field(string name, int got, int want);
		if (got != want)
			report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
	endtask

	task automatic send_line_pointer(line_ptr_t lp);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			items_if.valid = 1'b0;
			@(negedge clk);
		end
		items_if.valid = 1'b1;
		items_if.item_flag = lp.flag;
		items_if.item_offset = lp.offset;
		items_if.item_length = lp.length;
		items_if.last_item = lp.last;
		@(posedge clk);
		while (!items_if.ready)
			@(posedge clk);
		expected_verdicts.push_back(score_line_pointer(lp));
	endtask

	// Stops offering requests and waits until every result is back and the block is idle.
	task automatic settle();
		@(negedge clk);
		items_if.valid = 1'b0;
		while (expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [14:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == plpc_pkg::REG_UPPER)
			upper_reg = data;
		else if (idx == plpc_pkg::REG_SPECIAL)
			special_reg = data;
	endtask

	task automatic test_directed_cases();
		// Reset bounds: upper 0, special 32767.
		send_line_pointer(make_lp(plpc_pkg::FLAG_UNUSED, 0, 0, 0));
		send_line_pointer(make_lp(plpc_pkg::FLAG_UNUSED, 32767, 32767, 0));
		send_line_pointer(make_lp(plpc_pkg::FLAG_REDIRECT, 5, 0, 0));
		send_line_pointer(make_lp(plpc_pkg::FLAG_REDIRECT, 32767, 1, 0));
		send_line_pointer(make_lp(plpc_pkg::FLAG_DEAD, 0, 0, 0));
		send_line_pointer(make_lp(plpc_pkg::FLAG_NORMAL, 0, 0, 0));
		send_line_pointer(make_lp(plpc_pkg::FLAG_NORMAL, 32767, 32767, 0));
		send_line_pointer(make_lp(plpc_pkg::FLAG_NORMAL, 100, 100, 0));
		send_line_pointer(make_lp(plpc_pkg::FLAG_NORMAL, 100, 100, 0));
		send_line_pointer(make_lp(plpc_pkg::FLAG_NORMAL, 200, 50, 0));
		send_line_pointer(make_lp(plpc_pkg::FLAG_NORMAL, 150, 100, 0));
		send_line_pointer(make_lp(plpc_pkg::FLAG_DEAD, 120, 10, 0));
		send_line_pointer(make_lp(plpc_pkg::FLAG_NORMAL, 50, 300, 1));
		settle();
		write_reg(REG_SPARE_A, 15'h2AAA);
		write_reg(REG_SPARE_B, 15'h5555);
		write_reg(plpc_pkg::REG_UPPER, 15'd1000);
		write_reg(plpc_pkg::REG_SPECIAL, 15'd2000);
		send_line_pointer(make_lp(plpc_pkg::FLAG_NORMAL, 999, 1, 0));
		send_line_pointer(make_lp(plpc_pkg::FLAG_NORMAL, 1000, 1000, 0));
		send_line_pointer(make_lp(plpc_pkg::FLAG_NORMAL, 1500, 501, 0));
		send_line_pointer(make_lp(plpc_pkg::FLAG_DEAD, 1000, 0, 1));
		settle();
		write_reg(plpc_pkg::REG_UPPER, 15'd32767);
		write_reg(plpc_pkg::REG_SPECIAL, 15'd0);
		send_line_pointer(make_lp(plpc_pkg::FLAG_NORMAL, 32767, 0, 0));
		send_line_pointer(make_lp(plpc_pkg::FLAG_NORMAL, 1, 1, 1));
	endtask

	// Pages are mostly tuples packed down from the special area, with some overlaps,
	// dead, unused and redirect pointers, and fully random noise mixed in.
	task automatic test_random_pages(int target);
		int        sent, pages, n, cursor, kind, off, len, u;
		line_ptr_t lp;
		sent = 0;
		pages = 0;
		while (sent < target) begin
			if (pages % 6 == 0) begin
				settle();
				case ($urandom_range(5))
					0: begin
						write_reg(plpc_pkg::REG_UPPER, 15'd0);
						write_reg(plpc_pkg::REG_SPECIAL, 15'd32767);
					end
					1: begin
						write_reg(plpc_pkg::REG_UPPER, 15'd32767);
						write_reg(plpc_pkg::REG_SPECIAL, 15'd0);
					end
					2: begin
						write_reg(plpc_pkg::REG_UPPER, 15'($urandom_range(32767)));
						write_reg(plpc_pkg::REG_SPECIAL, 15'($urandom_range(32767)));
					end
					default: begin
						if ($urandom_range(1))
							write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B,
								15'($urandom_range(32767)));
						u = int'($urandom_range(12000));
						write_reg(plpc_pkg::REG_UPPER, 15'(u));
						write_reg(plpc_pkg::REG_SPECIAL, 15'($urandom_range(u + 4000, 32767)));
					end
				endcase
			end
			n = ($urandom_range(9) == 0) ? int'($urandom_range(30, 60)) :
				int'($urandom_range(1, 20));
			cursor = int'(special_reg);
			for (int i = 0; i < n; i++) begin
				kind = int'($urandom_range(99));
				if (kind < 68) begin
					len = int'($urandom_range(1, 300));
					if (cursor - len >= int'(upper_reg) && cursor - len >= 1) begin
						off = cursor - len;
						cursor = off;
					end else begin
						off = int'($urandom_range(1, 32767));
					end
					lp.flag = (kind < 58) ? plpc_pkg::FLAG_NORMAL : plpc_pkg::FLAG_DEAD;
				end else if (kind < 78) begin
					off = cursor + int'($urandom_range(40));
					if (off > 32767)
						off = 32767;
					len = int'($urandom_range(1, 400));
					lp.flag = plpc_pkg::FLAG_NORMAL;
				end else if (kind < 86) begin
					off = int'($urandom_range(32767));
					len = 0;
					lp.flag = plpc_pkg::FLAG_DEAD;
				end else if (kind < 94) begin
					off = int'($urandom_range(32767));
					len = ($urandom_range(3) == 0) ? int'($urandom_range(1, 32767)) : 0;
					lp.flag = $urandom_range(1) ? plpc_pkg::FLAG_REDIRECT :
						plpc_pkg::FLAG_UNUSED;
				end else begin
					off = int'($urandom_range(32767));
					len = int'($urandom_range(32767));
					lp.flag = 2'($urandom_range(3));
				end
				lp.offset = 15'(off);
				lp.length = 15'(len);
				lp.last = (i == n - 1);
				send_line_pointer(lp);
				sent++;
			end
			pages++;
		end
	endtask

	// Long spans starting close together overlap nearly all earlier ones, so the
	// table fills and the page total saturates.
	task automatic test_full_table();
		line_ptr_t lp;
		settle();
		write_reg(plpc_pkg::REG_UPPER, plpc_pkg::UPPER_RST);
		write_reg(plpc_pkg::REG_SPECIAL, plpc_pkg::SPECIAL_RST);
		for (int i = 0; i < plpc_pkg::MAX_SPANS + 8; i++) begin
			lp.flag = ($urandom_range(4) == 0) ? plpc_pkg::FLAG_DEAD : plpc_pkg::FLAG_NORMAL;
			lp.offset = 15'($urandom_range(100, 400));
			lp.length = 15'($urandom_range(20000, 30000));
			lp.last = (i == plpc_pkg::MAX_SPANS + 7);
			send_line_pointer(lp);
		end
	endtask

	task automatic test_receiver_holdoff();
		settle();
		hold_left = 400;
		for (int i = 0; i < 16; i++)
			send_line_pointer(make_lp(plpc_pkg::FLAG_NORMAL, 1000 + 50 * i,
				int'($urandom_range(30, 80)), i == 15));
		settle();
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			results_if.ready = 1'b0;
			hold_left--;
		end else begin
			results_if.ready = $urandom_range(99) >= recv_idle_pct;
		end
	end

	always @(posedge clk) begin
		if (arst_n && results_if.valid && results_if.ready) begin
			got_v.flag_len = results_if.flag_length_error;
			got_v.zero_len = results_if.zero_length_error;
			got_v.zero_off = results_if.zero_offset_error;
			got_v.below = results_if.below_upper_error;
			got_v.beyond = results_if.beyond_special_error;
			got_v.overlaps = results_if.overlap_count;
			got_v.item_errs = results_if.item_errors;
			got_v.page_total = results_if.page_errors;
			got_v.full = results_if.table_full;
			got_v.done = results_if.page_done;
			if (expected_verdicts.size() == 0) begin
				report_mismatch("result with no request outstanding");
			end else begin
				want_v = expected_verdicts.pop_front();
				compare_field("flag_length_error", int'(got_v.flag_len),
					int'(want_v.flag_len));
				compare_field("zero_length_error", int'(got_v.zero_len),
					int'(want_v.zero_len));
				compare_field("zero_offset_error", int'(got_v.zero_off),
					int'(want_v.zero_off));
				compare_field("below_upper_error", int'(got_v.below), int'(want_v.below));
				compare_field("beyond_special_error", int'(got_v.beyond),
					int'(want_v.beyond));
				compare_field("overlap_count", int'(got_v.overlaps), int'(want_v.overlaps));
				compare_field("item_errors", int'(got_v.item_errs), int'(want_v.item_errs));
				compare_field("page_errors", int'(got_v.page_total),
					int'(want_v.page_total));
				compare_field("table_full", int'(got_v.full), int'(want_v.full));
				compare_field("page_done", int'(got_v.done), int'(want_v.done));
			end
		end
	end

	initial begin
		#40000000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = plpc_pkg::REG_UPPER;
		cfg_data = '0;
		items_if.valid = 1'b0;
		items_if.item_flag = plpc_pkg::FLAG_UNUSED;
		items_if.item_offset = '0;
		items_if.item_length = '0;
		items_if.last_item = 1'b0;
		results_if.ready = 1'b0;
		send_idle_pct = 14;
		recv_idle_pct = 50;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		test_random_pages(220);
		send_idle_pct = 50;
		recv_idle_pct = 14;
		test_random_pages(200);
		test_full_table();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_pages(200);
		test_receiver_holdoff();

		settle();
		repeat (20) @(posedge clk);
		if (expected_verdicts.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_verdicts.size()));
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
